// ----- rtl/ltw_pkg.sv -----
// Package for the three-wire LCD frame sender.
// Holds opcodes, frame ids, frame lengths and the structs passed between modules.
// No dependencies.
package ltw_pkg;

    localparam int FRAME_W = 13;
    localparam int LEFT_W  = 4;

    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_WRITE  = 2'd1,
        OP_OPEN   = 2'd2,
        OP_NIBBLE = 2'd3
    } t_opcode;

    localparam logic [2:0] ID_CMD   = 3'b100;
    localparam logic [2:0] ID_WRITE = 3'b101;

    localparam logic [LEFT_W-1:0] LEN_CMD    = 4'd12;
    localparam logic [LEFT_W-1:0] LEN_WRITE  = 4'd13;
    localparam logic [LEFT_W-1:0] LEN_OPEN   = 4'd9;
    localparam logic [LEFT_W-1:0] LEN_NIBBLE = 4'd4;
    localparam logic [LEFT_W-1:0] LEN_NONE   = 4'd0;

    // Frame bits left aligned in transmit order: bit FRAME_W-1 goes out first.
    typedef struct packed {
        logic [FRAME_W-1:0] word;
        logic [LEFT_W-1:0]  len;
        logic               frame_begin;
        logic               frame_end;
    } t_frame;

    typedef struct packed {
        logic              busy;
        logic [LEFT_W-1:0] left;
    } t_ser_stat;

    // Nibbles go out LSB first, so they are stored reversed in the frame word.
    function automatic logic [3:0] rev4(input logic [3:0] v);
        rev4 = {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

// ----- rtl/ltw_ifs.sv -----
// Valid/ready channel interfaces of the three-wire LCD frame sender.
// Depends on nothing; field widths follow the item definitions.
interface ltw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [5:0] address;
    logic [7:0] payload;
    logic       close_frame;

    modport source(output valid, opcode, address, payload, close_frame, input ready);
    modport sink(input valid, opcode, address, payload, close_frame, output ready);
endinterface

interface ltw_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic frame_begin;
    logic frame_end;
    logic last;

    modport source(output valid, serial_bit, frame_begin, frame_end, last, input ready);
    modport sink(input valid, serial_bit, frame_begin, frame_end, last, output ready);
endinterface

// ----- rtl/ltw_loader.sv -----
// Frame loader: turns one input word into a frame word, length and flags.
// Keeps the burst-open state. Depends on ltw_pkg.
module ltw_loader
    import ltw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [1:0] i_opcode,
    input  logic [5:0] i_address,
    input  logic [7:0] i_payload,
    input  logic       i_close_frame,
    output t_frame     o_frame,
    output logic       o_burst_open
);

    logic r_burst_open;
    logic n_burst_open;

    always_comb begin
        o_frame      = '0;
        n_burst_open = r_burst_open;
        unique case (t_opcode'(i_opcode))
            OP_CMD: begin
                o_frame.word        = {ID_CMD, i_payload, 1'b0, 1'b0};
                o_frame.len         = LEN_CMD;
                o_frame.frame_begin = 1'b1;
                o_frame.frame_end   = 1'b1;
                n_burst_open        = 1'b0;
            end
            OP_WRITE: begin
                o_frame.word        = {ID_WRITE, i_address, rev4(i_payload[3:0])};
                o_frame.len         = LEN_WRITE;
                o_frame.frame_begin = 1'b1;
                o_frame.frame_end   = 1'b1;
                n_burst_open        = 1'b0;
            end
            OP_OPEN: begin
                o_frame.word        = {ID_WRITE, i_address, 4'b0000};
                o_frame.len         = LEN_OPEN;
                o_frame.frame_begin = 1'b1;
                o_frame.frame_end   = 1'b0;
                n_burst_open        = 1'b1;
            end
            OP_NIBBLE: begin
                // A nibble with no open frame yields a zero-length frame.
                o_frame.word        = {rev4(i_payload[3:0]), 9'b0};
                o_frame.len         = r_burst_open ? LEN_NIBBLE : LEN_NONE;
                o_frame.frame_begin = 1'b0;
                o_frame.frame_end   = i_close_frame;
                n_burst_open        = r_burst_open & ~i_close_frame;
            end
            default: begin
                o_frame = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_open <= 1'b0;
        end else if (i_load) begin
            r_burst_open <= n_burst_open;
        end
    end

    assign o_burst_open = r_burst_open;

endmodule

// ----- rtl/ltw_serializer.sv -----
// Bit serializer: shifts a loaded frame word out one bit per cycle, while the
// receiver does not stall, into an output register with valid/ready. Depends on ltw_pkg.
module ltw_serializer
    import ltw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_frame    i_frame,
    input  logic      i_out_ready,
    output logic      o_valid,
    output logic      o_serial_bit,
    output logic      o_frame_begin,
    output logic      o_frame_end,
    output logic      o_last,
    output t_ser_stat o_stat
);

    logic [FRAME_W-1:0] r_shift, n_shift;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic               r_first, n_first;
    logic               r_end, n_end;
    logic               r_valid, n_valid;
    logic               r_bit, n_bit;
    logic               r_begin, n_begin;
    logic               r_fend, n_fend;
    logic               r_last, n_last;
    logic               w_move;
    logic               w_final;

    assign w_move  = (r_left != LEN_NONE) && (!r_valid || i_out_ready);
    assign w_final = (r_left == 4'd1);

    always_comb begin
        n_shift = r_shift;
        n_left  = r_left;
        n_first = r_first;
        n_end   = r_end;
        n_valid = r_valid;
        n_bit   = r_bit;
        n_begin = r_begin;
        n_fend  = r_fend;
        n_last  = r_last;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        if (w_move) begin
            n_valid = 1'b1;
            n_bit   = r_shift[FRAME_W-1];
            n_begin = r_first;
            n_last  = w_final;
            n_fend  = w_final & r_end;
            n_shift = {r_shift[FRAME_W-2:0], 1'b0};
            n_left  = r_left - 4'd1;
            n_first = 1'b0;
        end else if (i_load) begin
            n_shift = i_frame.word;
            n_left  = i_frame.len;
            n_first = i_frame.frame_begin;
            n_end   = i_frame.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= LEN_NONE;
            r_valid <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_valid <= n_valid;
        end
        r_shift <= n_shift;
        r_first <= n_first;
        r_end   <= n_end;
        r_bit   <= n_bit;
        r_begin <= n_begin;
        r_fend  <= n_fend;
        r_last  <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_serial_bit  = r_bit;
    assign o_frame_begin = r_begin;
    assign o_frame_end   = r_fend;
    assign o_last        = r_last;
    assign o_stat.busy   = (r_left != LEN_NONE);
    assign o_stat.left   = r_left;

endmodule

// ----- rtl/lcd_three_wire_frame_sender.sv -----
// Top level of the three-wire segment-LCD frame sender.
// Depends on ltw_pkg, ltw_ifs, ltw_loader and ltw_serializer.
//
// Usage: the input channel i_in takes one word per request: a command, a
// single write, a burst open or a burst nibble. The output channel o_out
// carries one word per serial bit, in the order the bits go onto the data
// line, with frame_begin marking a chip-select fall before the bit,
// frame_end a chip-select rise after it, and last the final bit of a request.
// A command gives 12 bits, a single write 13, a burst open 9 and a nibble 4.
// A nibble with no burst open is accepted and dropped without output.
// An accepted request is loaded into the shift register; its first bit then
// moves into the output register once that register is free. Bits leave the
// shift register at one per cycle while the receiver takes them, and the bit
// counter of the serializer holds off the input until every bit has left.
// The next request is accepted as soon as the shift register is empty, even
// while the last bit still waits in the output register.
// When the receiver stalls, the output register holds its word and shifting
// pauses. Reset clears the burst-open state, the bit counter and the output
// valid flag; no frame is open after reset.
module lcd_three_wire_frame_sender
    import ltw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ltw_in_if.sink    i_in,
    ltw_out_if.source o_out
);

    t_frame    w_frame;
    t_ser_stat w_stat;
    logic      w_burst_open;
    logic      w_accept;

    // The serializer loads a new frame only once every bit of the last one
    // has moved into the output register.
    assign i_in.ready = !w_stat.busy;
    assign w_accept   = i_in.valid && i_in.ready;

    ltw_loader u_loader (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_opcode      (i_in.opcode),
        .i_address     (i_in.address),
        .i_payload     (i_in.payload),
        .i_close_frame (i_in.close_frame),
        .o_frame       (w_frame),
        .o_burst_open  (w_burst_open)
    );

    ltw_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_frame       (w_frame),
        .i_out_ready   (o_out.ready),
        .o_valid       (o_out.valid),
        .o_serial_bit  (o_out.serial_bit),
        .o_frame_begin (o_out.frame_begin),
        .o_frame_end   (o_out.frame_end),
        .o_last        (o_out.last),
        .o_stat        (w_stat)
    );

    // A command loads exactly twelve bits into the serializer.
    a_cmd_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_CMD) |=> (w_stat.left == LEN_CMD))
        else $error("command frame length wrong");

    // A nibble with no open burst leaves the serializer empty.
    a_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_NIBBLE && !w_burst_open) |=> !w_stat.busy)
        else $error("dropped nibble produced bits");

    // Chip select only rises after the final bit of a request.
    a_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> o_out.last)
        else $error("frame end before last bit");

    // A burst open leaves a burst frame open.
    a_open_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_OPEN) |=> w_burst_open)
        else $error("burst open did not open a frame");

endmodule

// ----- tb/sv/lcd_three_wire_frame_sender_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of lcd_three_wire_frame_sender.
// It predicts every serial bit of each request and compares the output words.
// Depends on ltw_pkg, ltw_ifs and the RTL of the block.
module lcd_three_wire_frame_sender_tb;
    import ltw_pkg::*;

    // Longest run of cycles in which no word moves on either channel.
    localparam int STALL_LIMIT  = 2000;
    // Cycles allowed after the last expected bit, so that a dropped nibble
    // or a late extra bit can still show up before the next phase.
    localparam int DRAIN_CYCLES = 32;
    // Random requests per idling phase; with the directed requests the run
    // sends about 180.
    localparam int PHASE_REQS   = 38;

    // One request word on the input channel.
    typedef struct {
        t_opcode    opcode;
        logic [5:0] address;
        logic [7:0] payload;
        logic       close_frame;
    } t_lcd_req;

    // One serial bit word on the output channel.
    typedef struct {
        logic serial_bit;
        logic frame_begin;
        logic frame_end;
        logic last;
    } t_lcd_bit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ltw_in_if  req_ch();
    ltw_out_if bit_ch();

    lcd_three_wire_frame_sender u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (bit_ch)
    );

    // Requests not yet accepted; the front one is on the channel while
    // valid is high.
    t_lcd_req req_backlog[$];
    // Serial bits that the accepted requests still owe, oldest first.
    t_lcd_bit bits_due[$];
    // Our own copy of the burst state: a burst frame is open.
    logic     burst_open_mirror;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    // Idle and stall rates in percent for the current phase.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Works out the serial bits of one accepted request and appends them to
    // bits_due. The bits are packed left aligned into a 13-bit sequence, the
    // first bit to go out in the top position.
    function automatic void predict_serial_bits(input t_lcd_req r);
        logic [12:0] seq;
        int          len;
        logic        opens;
        logic        closes;
        t_lcd_bit    b;

        seq    = '0;
        len    = 0;
        opens  = 1'b0;
        closes = 1'b0;
        case (r.opcode)
            OP_CMD: begin
                // Header, command byte MSB first, one zero bit, then padding.
                seq    = {ID_CMD, r.payload, 1'b0, 1'b0};
                len    = 12;
                opens  = 1'b1;
                closes = 1'b1;
                burst_open_mirror = 1'b0;
            end
            OP_WRITE: begin
                // Address goes MSB first, the data nibble LSB first.
                seq    = {ID_WRITE, r.address, r.payload[0], r.payload[1],
                          r.payload[2], r.payload[3]};
                len    = 13;
                opens  = 1'b1;
                closes = 1'b1;
                burst_open_mirror = 1'b0;
            end
            OP_OPEN: begin
                // A header while a burst is open just starts a new frame.
                seq   = {ID_WRITE, r.address, 4'b0000};
                len   = 9;
                opens = 1'b1;
                burst_open_mirror = 1'b1;
            end
            default: begin
                // A nibble with no open frame is swallowed without output.
                if (burst_open_mirror) begin
                    seq    = {r.payload[0], r.payload[1], r.payload[2],
                              r.payload[3], 9'd0};
                    len    = 4;
                    closes = r.close_frame;
                    if (r.close_frame) begin
                        burst_open_mirror = 1'b0;
                    end
                end
            end
        endcase

        for (int i = 0; i < len; i++) begin
            b.serial_bit  = seq[12 - i];
            b.frame_begin = opens && (i == 0);
            b.frame_end   = closes && (i == len - 1);
            b.last        = (i == len - 1);
            bits_due.push_back(b);
        end
    endfunction

    // Driver: presents the front of the backlog and holds it until the
    // block takes the word. Idle cycles are only inserted between words.
    always @(posedge i_clk) begin : req_driver
        t_lcd_req taken;
        logic     hold;

        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            burst_open_mirror = 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                taken = req_backlog.pop_front();
                predict_serial_bits(taken);
            end
            hold = req_ch.valid && !req_ch.ready;
            if (!hold) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    req_ch.valid       <= 1'b1;
                    req_ch.opcode      <= req_backlog[0].opcode;
                    req_ch.address     <= req_backlog[0].address;
                    req_ch.payload     <= req_backlog[0].payload;
                    req_ch.close_frame <= req_backlog[0].close_frame;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes each bit word, checks it field by field against the
    // oldest expectation, and stalls the block at random.
    always @(posedge i_clk) begin : bit_monitor
        t_lcd_bit want;

        if (!i_rst_n) begin
            bit_ch.ready <= 1'b0;
        end else begin
            if (bit_ch.valid && bit_ch.ready) begin
                if (bits_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected bit word %b/%b/%b/%b",
                        bit_ch.serial_bit, bit_ch.frame_begin,
                        bit_ch.frame_end, bit_ch.last));
                end else begin
                    want = bits_due.pop_front();
                    if (bit_ch.serial_bit !== want.serial_bit) begin
                        report_mismatch($sformatf("serial_bit %b, expected %b",
                            bit_ch.serial_bit, want.serial_bit));
                    end
                    if (bit_ch.frame_begin !== want.frame_begin) begin
                        report_mismatch($sformatf("frame_begin %b, expected %b",
                            bit_ch.frame_begin, want.frame_begin));
                    end
                    if (bit_ch.frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("frame_end %b, expected %b",
                            bit_ch.frame_end, want.frame_end));
                    end
                    if (bit_ch.last !== want.last) begin
                        report_mismatch($sformatf("last %b, expected %b",
                            bit_ch.last, want.last));
                    end
                end
            end
            bit_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: any cycle that moves a word on either channel resets the
    // count; a long run of dead cycles means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (bit_ch.valid && bit_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("lcd_three_wire_frame_sender_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_req(input t_opcode op, input logic [5:0] addr,
                                      input logic [7:0] data, input logic close);
        t_lcd_req r;

        r.opcode      = op;
        r.address     = addr;
        r.payload     = data;
        r.close_frame = close;
        req_backlog.push_back(r);
    endfunction

    // Pushes one group of random requests and returns how many. Most groups
    // are well formed bursts, so that nibbles actually reach an open frame;
    // the rest are single frames and fully random noise.
    function automatic int queue_random_group();
        int sel;
        int count;
        int nibbles;

        sel   = $urandom_range(99);
        count = 0;
        if (sel < 60) begin
            queue_req(OP_OPEN, 6'($urandom_range(63)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
            count++;
            nibbles = $urandom_range(1, 6);
            for (int i = 0; i < nibbles; i++) begin
                // Usually close on the last nibble; sometimes leave the frame
                // open so that the next header closes it.
                queue_req(OP_NIBBLE, 6'($urandom_range(63)), 8'($urandom_range(255)),
                          (i == nibbles - 1) && ($urandom_range(3) != 0));
                count++;
            end
        end else if (sel < 80) begin
            queue_req(($urandom_range(1) != 0) ? OP_WRITE : OP_CMD,
                      6'($urandom_range(63)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
            count++;
        end else begin
            queue_req(t_opcode'(2'($urandom_range(3))), 6'($urandom_range(63)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
            count++;
        end
        return count;
    endfunction

    // Returns once every request is taken and every bit has come, plus a
    // grace period for requests that give no bits.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_ch.valid || bits_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int pushed;

        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_CMD;
        req_ch.address     = '0;
        req_ch.payload     = '0;
        req_ch.close_frame = 1'b0;
        bit_ch.ready       = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, no idling. Commands at the byte extremes; the
        // address and close fields must not matter for a command.
        queue_req(OP_CMD, 6'd0, 8'h00, 1'b0);
        queue_req(OP_CMD, 6'd63, 8'hFF, 1'b1);
        queue_req(OP_CMD, 6'd21, 8'hA5, 1'b0);
        // Single writes; only the low nibble of the payload is sent.
        queue_req(OP_WRITE, 6'd0, 8'h00, 1'b0);
        queue_req(OP_WRITE, 6'd63, 8'hFF, 1'b1);
        queue_req(OP_WRITE, 6'd42, 8'hC5, 1'b0);
        // Nibbles after a write, with no burst open, are dropped.
        queue_req(OP_NIBBLE, 6'd0, 8'h0F, 1'b1);
        queue_req(OP_NIBBLE, 6'd63, 8'hF0, 1'b0);
        // A full burst closed by its last nibble, then a stray nibble.
        queue_req(OP_OPEN, 6'd63, 8'hFF, 1'b1);
        queue_req(OP_NIBBLE, 6'd0, 8'h0F, 1'b0);
        queue_req(OP_NIBBLE, 6'd0, 8'hF0, 1'b0);
        queue_req(OP_NIBBLE, 6'd0, 8'hA3, 1'b1);
        queue_req(OP_NIBBLE, 6'd0, 8'h55, 1'b1);
        // A command closes an open burst; the nibble after it is dropped.
        queue_req(OP_OPEN, 6'd0, 8'h00, 1'b0);
        queue_req(OP_NIBBLE, 6'd5, 8'h96, 1'b0);
        queue_req(OP_CMD, 6'd0, 8'h81, 1'b0);
        queue_req(OP_NIBBLE, 6'd0, 8'h3C, 1'b1);
        // A burst header on top of an open burst starts a fresh frame.
        queue_req(OP_OPEN, 6'd21, 8'h00, 1'b0);
        queue_req(OP_OPEN, 6'd42, 8'hFF, 1'b1);
        queue_req(OP_NIBBLE, 6'd63, 8'h69, 1'b1);
        // A single write closes an open burst as well.
        queue_req(OP_OPEN, 6'd1, 8'h00, 1'b0);
        queue_req(OP_WRITE, 6'd32, 8'h7E, 1'b1);
        queue_req(OP_NIBBLE, 6'd0, 8'hE7, 1'b0);
        wait_drained();

        // Random part in four idling phases: none, sender gaps, receiver
        // stalls, and both at once.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 67; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            pushed = 0;
            while (pushed < PHASE_REQS) begin
                pushed += queue_random_group();
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("lcd_three_wire_frame_sender_tb passed");
        end else begin
            $display("lcd_three_wire_frame_sender_tb failed");
        end
        $finish;
    end

endmodule
